[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL.
// Each check is clocked on clk and disabled while rst is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

[rtl/ssc_pkg.sv]
package ssc_pkg;

  // Configuration port widths and register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES_0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES_1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES_2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_BYTES_3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_START       = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_REPORT_ALL      = 3'd6;

  // Pattern storage held in configuration
  localparam int PAT_BYTES = 32;
  localparam int PAT_REGS  = 4;

  // Result queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = 2;
  localparam int QCNT_W      = 3;

  // One result item
  typedef struct packed {
    logic [7:0] match_position;
    logic       found;
    logic       search_done;
  } res_t;

  // Front to queue: one result request
  typedef struct packed {
    logic push;
    res_t res;
  } q_push_t;

  // Queue to front: fill status
  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

endpackage

[rtl/substring_search_core.sv]
// Streaming substring search. Text bytes enter on the s_ group, one per
// cycle, with s_tlast on the final byte of a text. Each byte shifts into a
// window of the last PATTERN_MAX bytes and is compared combinationally with the
// configured pattern; a hit reports the start position of the occurrence
// (overlaps included, not before the configured earliest start, only the
// first one of a text unless report_all is set). The final byte of a text
// always yields a result with m_tlast high, m_tuser low if no reported hit
// ends there. Results pass through a four-entry queue, so input runs at one
// byte per cycle until four results wait untaken at the m_ group. A
// configuration write holds s_tready low for the following cycle while the
// pattern realignment register reloads; s_tready is also low for the first
// cycle after reset.
`include "assert_macros.svh"

module substring_search_core #(
  parameter int PATTERN_MAX = 32,
  parameter int TEXT_MAX    = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  // Configuration write channel
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data,
  // Text input
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [7:0]                    s_tdata,   // [7:0] text_byte
  input  logic                          s_tlast,   // text_end
  // Results
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [7:0]                    m_tdata,   // [7:0] match_position
  output logic                          m_tuser,   // found
  output logic                          m_tlast    // search_done
);

  ssc_pkg::q_push_t   q_push;
  ssc_pkg::q_status_t q_status;
  ssc_pkg::res_t      out_res;

  ssc_front #(
    .PATTERN_MAX (PATTERN_MAX),
    .TEXT_MAX    (TEXT_MAX)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .text_byte (s_tdata),
    .text_end  (s_tlast),
    .q_status  (q_status),
    .q_push    (q_push)
  );

  ssc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .q_push    (q_push),
    .q_status  (q_status),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = out_res.match_position;
  assign m_tuser = out_res.found;
  assign m_tlast = out_res.search_done;

  // Checks
  `ASSERT_IMPL(a_nohit_zero_pos, m_tvalid && !m_tuser, m_tdata == 8'd0)
  `ASSERT_IMPL(a_nohit_is_done, m_tvalid && !m_tuser, m_tlast)
  `ASSERT_NEXT(a_last_gives_result, s_tvalid && s_tready && s_tlast, m_tvalid)
  `ASSERT_NEXT(a_cfg_settle, cfg_valid && cfg_ready, !s_tready)

endmodule

[rtl/ssc_front.sv]
module ssc_front #(
  parameter int PATTERN_MAX = 32,
  parameter int TEXT_MAX    = 256
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [ssc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [ssc_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [7:0]                    text_byte,
  input  logic                          text_end,
  input  ssc_pkg::q_status_t            q_status,
  output ssc_pkg::q_push_t              q_push
);

  localparam int IDX_W = $clog2(TEXT_MAX + 1);
  localparam int BW    = (IDX_W + 1 > 9) ? IDX_W + 1 : 9;

  // Configuration registers
  logic [5:0]                        pattern_length;
  logic [ssc_pkg::PAT_BYTES*8-1:0]   pattern;
  logic [7:0]                        min_start;
  logic                              report_all;

  // Pattern realigned to the window: entry j faces the newest byte j
  logic [PATTERN_MAX-1:0][7:0]       rpat;
  logic [PATTERN_MAX-1:0][7:0]       rpat_next;
  logic [PATTERN_MAX-1:0]            mask;
  logic [PATTERN_MAX-1:0]            mask_next;
  logic                              len_ok;
  logic                              len_ok_next;
  logic                              settle;

  // Search state
  logic [PATTERN_MAX-1:0][7:0]       window;
  logic [PATTERN_MAX-1:0][7:0]       window_next;
  logic [IDX_W-1:0]                  byte_index;
  logic                              first_reported;

  logic                              accept;
  logic                              cfg_we;
  logic [PATTERN_MAX-1:0]            eq;
  logic                              match_all;
  logic                              pos_lt;
  logic [BW-1:0]                     pos1;
  logic [BW-1:0]                     len_w;
  logic [BW-1:0]                     begin_pos;
  logic                              enough;
  logic                              begin_ok;
  logic                              hit;

  assign cfg_ready = 1'b1;
  assign cfg_we    = cfg_valid & cfg_ready;
  assign in_ready  = ~settle & ~q_status.full;
  assign accept    = in_valid & in_ready;

  // Write configuration registers; hold input while the realignment reloads
  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= 6'd1;
      pattern        <= '0;
      min_start      <= 8'd0;
      report_all     <= 1'b0;
      settle         <= 1'b1;
    end else begin
      settle <= cfg_we;
      if (cfg_we) begin
        case (cfg_index)
          ssc_pkg::CFG_PATTERN_LENGTH:  pattern_length <= cfg_data[5:0];
          ssc_pkg::CFG_PATTERN_BYTES_0: pattern[0*64 +: 64] <= cfg_data;
          ssc_pkg::CFG_PATTERN_BYTES_1: pattern[1*64 +: 64] <= cfg_data;
          ssc_pkg::CFG_PATTERN_BYTES_2: pattern[2*64 +: 64] <= cfg_data;
          ssc_pkg::CFG_PATTERN_BYTES_3: pattern[3*64 +: 64] <= cfg_data;
          ssc_pkg::CFG_MIN_START:       min_start <= cfg_data[7:0];
          ssc_pkg::CFG_REPORT_ALL:      report_all <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Realign the pattern so that byte len-1-j faces window entry j
  always_comb begin
    logic [5:0] k;
    for (int j = 0; j < PATTERN_MAX; j++) begin
      k            = pattern_length - 6'(j) - 6'd1;
      mask_next[j] = {1'b0, 6'(j)} < {1'b0, pattern_length};
      if (mask_next[j] && !k[5]) begin
        rpat_next[j] = pattern[{k[4:0], 3'b000} +: 8];
      end else begin
        rpat_next[j] = 8'd0;
      end
    end
    len_ok_next = (pattern_length != 6'd0) &&
                  ({1'b0, pattern_length} <= 7'(PATTERN_MAX));
  end

  always_ff @(posedge clk) begin
    rpat   <= rpat_next;
    mask   <= mask_next;
    len_ok <= len_ok_next;
  end

  // Shift the new byte into the window, newest at entry 0
  always_comb begin
    window_next[0] = text_byte;
    for (int j = 1; j < PATTERN_MAX; j++) begin
      window_next[j] = window[j-1];
    end
    for (int j = 0; j < PATTERN_MAX; j++) begin
      eq[j] = (window_next[j] == rpat[j]) | ~mask[j];
    end
    match_all = &eq;
  end

  // Classify the byte: position checks and hit decision
  assign pos_lt    = byte_index < IDX_W'(TEXT_MAX);
  assign pos1      = BW'(byte_index) + BW'(1);
  assign len_w     = BW'(pattern_length);
  assign enough    = pos1 >= len_w;
  assign begin_pos = pos1 - len_w;
  assign begin_ok  = begin_pos >= BW'(min_start);
  assign hit       = pos_lt & len_ok & enough & begin_ok & match_all &
                     (report_all | ~first_reported);

  // Advance window, index and first-hit flag
  always_ff @(posedge clk) begin
    if (rst) begin
      window         <= '0;
      byte_index     <= '0;
      first_reported <= 1'b0;
    end else if (accept) begin
      window <= window_next;
      if (text_end) begin
        byte_index     <= '0;
        first_reported <= 1'b0;
      end else begin
        if (pos_lt) byte_index <= byte_index + IDX_W'(1);
        if (hit) first_reported <= 1'b1;
      end
    end
  end

  // Request a result for a hit or the final byte
  always_comb begin
    q_push.push               = accept & (hit | text_end);
    q_push.res.match_position = hit ? begin_pos[7:0] : 8'd0;
    q_push.res.found          = hit;
    q_push.res.search_done    = text_end;
  end

endmodule

[rtl/ssc_queue.sv]
module ssc_queue (
  input  logic               clk,
  input  logic               rst,
  input  ssc_pkg::q_push_t   q_push,
  output ssc_pkg::q_status_t q_status,
  output logic               out_valid,
  input  logic               out_ready,
  output ssc_pkg::res_t      out_res
);

  ssc_pkg::res_t                   entries [ssc_pkg::QUEUE_DEPTH];
  logic [ssc_pkg::QPTR_W-1:0]      wr_ptr;
  logic [ssc_pkg::QPTR_W-1:0]      rd_ptr;
  logic [ssc_pkg::QCNT_W-1:0]      count;
  logic                            pop;

  assign q_status.full  = count == ssc_pkg::QCNT_W'(ssc_pkg::QUEUE_DEPTH);
  assign q_status.empty = count == '0;
  assign out_valid      = ~q_status.empty;
  assign out_res        = entries[rd_ptr];
  assign pop            = out_valid & out_ready;

  // Store a result request
  always_ff @(posedge clk) begin
    if (q_push.push) entries[wr_ptr] <= q_push.res;
  end

  // Advance pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (q_push.push) wr_ptr <= wr_ptr + ssc_pkg::QPTR_W'(1);
      if (pop) rd_ptr <= rd_ptr + ssc_pkg::QPTR_W'(1);
      case ({q_push.push, pop})
        2'b10:   count <= count + ssc_pkg::QCNT_W'(1);
        2'b01:   count <= count - ssc_pkg::QCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule
